// File: src/pfa_pkg.sv
// Package: shared constants, codes and types of the partition fit allocator.
`default_nettype none
package pfa_pkg;

   localparam int PARTITIONS = 32;
   localparam int SIZE_BITS  = 16;

   localparam int IDX_BITS = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
   localparam int CNT_BITS = $clog2(PARTITIONS + 1);

   // Field widths fixed by the interface
   localparam int KIND_W     = 1;
   localparam int LOAD_IDX_W = 5;
   localparam int SIZE_W     = 16;
   localparam int PICK_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_COUNT = 1'b1;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      fit_mode_type    fit_mode;
      logic [CSR_DATA_W-1:0] partition_count;
   } cfg_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_BITS-1:0]  addr;
      logic [SIZE_BITS-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              granted;
      logic [PICK_W-1:0] chosen_partition;
      logic [SIZE_W-1:0] leftover_space;
   } result_type;

endpackage
`default_nettype wire

// File: src/pfa_ram.sv
// Free-space memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module pfa_ram (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pfa_pkg::mem_wr_type               wr,
   input  wire logic                              rd_en,
   input  wire logic [pfa_pkg::IDX_BITS-1:0]      rd_addr,
   output logic      [pfa_pkg::SIZE_BITS-1:0]     rd_data
);

   logic [pfa_pkg::SIZE_BITS-1:0]  mem [pfa_pkg::PARTITIONS];
   logic [pfa_pkg::PARTITIONS-1:0] valid_ff;
   logic [pfa_pkg::SIZE_BITS-1:0]  q_ff;
   logic                           qv_ff;

   // Entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff  <= mem[rd_addr];
         qv_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule
`default_nettype wire

// File: src/pfa_ctrl.sv
// Sequencer: loads, memory scan with fit selection, write-back and result push.
`default_nettype none
module pfa_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pfa_pkg::cfg_type                  cfg,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pfa_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [pfa_pkg::LOAD_IDX_W-1:0]    req_load_index,
   input  wire logic [pfa_pkg::SIZE_W-1:0]        req_size_value,
   input  wire logic                              slot_free,
   output logic                                   res_push,
   output pfa_pkg::result_type                    res
);

   localparam int IW = pfa_pkg::IDX_BITS;
   localparam int CW = pfa_pkg::CNT_BITS;
   localparam int SW = pfa_pkg::SIZE_BITS;

   pfa_pkg::state_type    state_ff, state_in;
   pfa_pkg::fit_mode_type mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic [IW-1:0] rd_addr_ff, rd_addr_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_addr_ff, cmp_addr_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [SW-1:0] best_ff, best_in;
   logic [SW-1:0] size_ff, size_in;
   logic [IW-1:0] next_start_ff, next_start_in;
   logic [pfa_pkg::PARTITIONS-1:0] used_ff, used_in;

   pfa_pkg::mem_wr_type mem_wr;
   logic                rd_en;
   logic [SW-1:0]       rd_data;

   logic          accept;
   logic          is_load;
   logic          load_ok;
   logic [CW-1:0] active_count;
   logic [SW-1:0] req_size;
   logic [SW-1:0] diff;
   logic          fits;
   logic          take;
   logic [SW-1:0] take_val;
   logic [SW-1:0] leftover;
   logic          scan_end;

   pfa_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign accept   = req_valid && !req_stall;
   assign is_load  = (req_kind == pfa_pkg::KIND_LOAD);
   assign load_ok  = 32'(req_load_index) < 32'(pfa_pkg::PARTITIONS);
   assign req_size = SW'(req_size_value);
   assign active_count = (32'(cfg.partition_count) > 32'(pfa_pkg::PARTITIONS)) ?
                         CW'(pfa_pkg::PARTITIONS) : CW'(cfg.partition_count);
   assign rd_en    = (state_ff == pfa_pkg::ST_SCAN) && (issued_ff != count_ff);
   assign scan_end = !rd_en && !cmp_vld_ff;

   // Fit selection on the entry returned by the memory
   assign diff = rd_data - size_ff;
   assign fits = rd_data >= size_ff;
   always_comb begin
      case (mode_ff)
         pfa_pkg::FIT_BEST: begin
            take     = fits && !used_ff[cmp_addr_ff] && (!found_ff || diff < best_ff);
            take_val = diff;
         end
         pfa_pkg::FIT_WORST: begin
            take     = fits && (!found_ff || rd_data > best_ff);
            take_val = rd_data;
         end
         default: begin
            take     = fits && !found_ff;
            take_val = rd_data;
         end
      endcase
   end

   assign leftover = (mode_ff == pfa_pkg::FIT_BEST) ? best_ff : best_ff - size_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept && !is_load) state_in = pfa_pkg::ST_SCAN;
         end
         pfa_pkg::ST_SCAN: begin
            if (scan_end) state_in = pfa_pkg::ST_DONE;
         end
         pfa_pkg::ST_DONE: begin
            if (slot_free) state_in = pfa_pkg::ST_IDLE;
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall   = 1'b1;
      res_push    = 1'b0;
      mem_wr.en   = 1'b0;
      mem_wr.addr = IW'(req_load_index);
      mem_wr.data = req_size;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mem_wr.en = accept && is_load && load_ok;
         end
         pfa_pkg::ST_DONE: begin
            res_push    = slot_free;
            mem_wr.en   = slot_free && found_ff && (mode_ff != pfa_pkg::FIT_BEST);
            mem_wr.addr = pick_ff;
            mem_wr.data = leftover;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign res.granted          = found_ff;
   assign res.chosen_partition = found_ff ? pfa_pkg::PICK_W'(pick_ff) : '0;
   assign res.leftover_space   = found_ff ? pfa_pkg::SIZE_W'(leftover) : '0;

   // Datapath next values
   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      issued_in     = issued_ff;
      rd_addr_in    = rd_addr_ff;
      cmp_vld_in    = 1'b0;
      cmp_addr_in   = rd_addr_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      size_in       = size_ff;
      next_start_in = next_start_ff;
      used_in       = used_ff;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept && is_load && load_ok) begin
               used_in[IW'(req_load_index)] = 1'b0;
            end
            if (accept && !is_load) begin
               mode_in   = cfg.fit_mode;
               count_in  = active_count;
               size_in   = req_size;
               issued_in = '0;
               found_in  = 1'b0;
               pick_in   = '0;
               best_in   = '0;
               if (cfg.fit_mode == pfa_pkg::FIT_NEXT &&
                   CW'(next_start_ff) < active_count) begin
                  rd_addr_in = next_start_ff;
               end else begin
                  rd_addr_in = '0;
               end
            end
         end
         pfa_pkg::ST_SCAN: begin
            cmp_vld_in = rd_en;
            if (rd_en) begin
               issued_in  = issued_ff + CW'(1);
               rd_addr_in = (CW'(rd_addr_ff) + CW'(1) == count_ff) ?
                            '0 : rd_addr_ff + IW'(1);
            end
            if (cmp_vld_ff && take) begin
               found_in = 1'b1;
               pick_in  = cmp_addr_ff;
               best_in  = take_val;
            end
         end
         pfa_pkg::ST_DONE: begin
            if (slot_free && found_ff) begin
               if (mode_ff == pfa_pkg::FIT_BEST) begin
                  used_in[pick_ff] = 1'b1;
               end
               if (mode_ff == pfa_pkg::FIT_NEXT) begin
                  next_start_in = (CW'(pick_ff) + CW'(1) < count_ff) ?
                                  pick_ff + IW'(1) : '0;
               end
            end
         end
         default: begin
            cmp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfa_pkg::ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         next_start_ff <= '0;
         used_ff       <= '0;
         issued_ff     <= '0;
         count_ff      <= '0;
         found_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         next_start_ff <= next_start_in;
         used_ff       <= used_in;
         issued_ff     <= issued_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rd_addr_ff  <= rd_addr_in;
      cmp_addr_ff <= cmp_addr_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      size_ff     <= size_in;
   end

   // Reads and writes never share a cycle, so no forwarding path is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && mem_wr.en))
      else $error("memory read and write in the same cycle");

   a_push_needs_slot: assert property (@(posedge clock) disable iff (reset)
      res_push |-> slot_free)
      else $error("result pushed into a full output slot");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      (res_push && found_ff) |-> (CW'(pick_ff) < count_ff))
      else $error("granted partition outside the searched range");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfa_pkg::ST_SCAN) |-> (issued_ff <= count_ff))
      else $error("scan issued more reads than partitions");

endmodule
`default_nettype wire

// File: src/partition_fit_allocator.sv
// A request's result is registered after the scan and the write-back; a stalled result
// holds the block in write-back. A new request waits until the last one is done, as the scan
// walks the single read port of the free-space memory one entry a cycle; a load is written
// in the cycle that it is accepted.
// Reset (synchronous, active high) zeroes free sizes, used marks, the round-robin pointer,
// fit mode and partition count, and empties the result register; CSRs are always ready.
`default_nettype none
module partition_fit_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pfa_pkg::KIND_W-1:0]        req_kind,
   input  wire logic [pfa_pkg::LOAD_IDX_W-1:0]    req_load_index,
   input  wire logic [pfa_pkg::SIZE_W-1:0]        req_size_value,
   // response channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_granted,
   output logic      [pfa_pkg::PICK_W-1:0]        rsp_chosen_partition,
   output logic      [pfa_pkg::SIZE_W-1:0]        rsp_leftover_space,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pfa_pkg::cfg_type    cfg_ff, cfg_in;
   pfa_pkg::result_type res;
   pfa_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                res_push;
   logic                slot_free;

   // Configuration registers: always take the transaction
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pfa_pkg::CSR_FIT_MODE:   cfg_in.fit_mode = pfa_pkg::fit_mode_type'(csr_wdata[1:0]);
            pfa_pkg::CSR_PART_COUNT: cfg_in.partition_count = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Output slot frees when empty or drained in this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   pfa_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_load_index (req_load_index),
      .req_size_value (req_size_value),
      .slot_free      (slot_free),
      .res_push       (res_push),
      .res            (res)
   );

   // Hold the result until the transaction completes, then drop it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{fit_mode: pfa_pkg::FIT_FIRST, partition_count: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_granted          = rsp_ff.granted;
   assign rsp_chosen_partition = rsp_ff.chosen_partition;
   assign rsp_leftover_space   = rsp_ff.leftover_space;

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the partition fit allocator: directed table, then random traffic.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pfa_pkg::*;

   // Settle wait: the longest request, which scans every partition, with padding.
   localparam int SETTLE_CYCLES = 3 + PARTITIONS + 5;
   localparam int RUN_LIMIT     = 1_000_000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 250;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ALLOC,
      OP_MODE,
      OP_COUNT
   } step_op_type;

   // One directed step. For OP_MODE and OP_COUNT, value carries the register data.
   typedef struct packed {
      step_op_type       op;
      logic [4:0]        index;
      logic [15:0]       value;
      bit                typed;
      result_type        want;
   } dir_row_type;

   localparam result_type REFUSED = '{1'b0, 5'd0, 16'd0};
   localparam result_type NONE    = '0;

   // Rows with typed results can be read straight off the fit rules; the rest
   // go through the allocation predictor.
   localparam dir_row_type DIRECTED_ROWS [30] = '{
      // after reset: no partitions searched, so refuse
      '{OP_ALLOC, 5'd0,  16'd0,            1'b1, REFUSED},
      // count above the table size searches the whole table
      '{OP_COUNT, 5'd0,  16'd63,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'hFFFF,         1'b1, REFUSED},
      '{OP_LOAD,  5'd0,  16'hFFFF,         1'b0, NONE},
      '{OP_LOAD,  5'd31, 16'd100,          1'b0, NONE},
      '{OP_LOAD,  5'd5,  16'd300,          1'b0, NONE},
      // first fit: full-size request drains partition zero exactly
      '{OP_ALLOC, 5'd31, 16'hFFFF,         1'b1, '{1'b1, 5'd0, 16'd0}},
      '{OP_ALLOC, 5'd0,  16'd0,            1'b1, '{1'b1, 5'd0, 16'd0}},
      '{OP_ALLOC, 5'd0,  16'd200,          1'b1, '{1'b1, 5'd5, 16'd100}},
      '{OP_ALLOC, 5'd0,  16'hFFFF,         1'b1, REFUSED},
      '{OP_MODE,  5'd0,  16'(FIT_WORST),   1'b0, NONE},
      '{OP_LOAD,  5'd3,  16'd1000,         1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd50,           1'b0, NONE},
      // best fit: tie on leftover, then used marks steer later picks
      '{OP_MODE,  5'd0,  16'(FIT_BEST),    1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd90,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd90,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd90,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd0,            1'b0, NONE},
      // a load clears the used mark
      '{OP_LOAD,  5'd5,  16'd100,          1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd100,          1'b0, NONE},
      // next fit, then shrink the count under the round-robin pointer
      '{OP_MODE,  5'd0,  16'(FIT_NEXT),    1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd10,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd10,           1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd10,           1'b0, NONE},
      '{OP_COUNT, 5'd0,  16'd4,            1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd1,            1'b0, NONE},
      '{OP_COUNT, 5'd0,  16'd1,            1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'd0,            1'b0, NONE},
      '{OP_COUNT, 5'd0,  16'd0,            1'b0, NONE},
      '{OP_ALLOC, 5'd0,  16'h5555,         1'b1, REFUSED}
   };

   // DUT pins; the driven ones are all known from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind       = KIND_LOAD;
   logic [LOAD_IDX_W-1:0] req_load_index = '0;
   logic [SIZE_W-1:0]     req_size_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic                  rsp_granted;
   logic [PICK_W-1:0]     rsp_chosen_partition;
   logic [SIZE_W-1:0]     rsp_leftover_space;
   logic                  csr_valid      = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index      = CSR_FIT_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // Typed expectation riding along with the offered transaction
   bit                    row_typed      = 1'b0;
   result_type            row_want       = '0;

   // Allocation predictor state: mirrors the block's table and registers
   logic [SIZE_W-1:0]     part_free [PARTITIONS] = '{default: '0};
   bit                    part_taken [PARTITIONS] = '{default: 1'b0};
   int unsigned           rr_ptr    = 0;
   fit_mode_type          cur_mode  = FIT_FIRST;
   logic [CSR_DATA_W-1:0] cur_count = '0;

   result_type            alloc_expect_q [$];

   int                    mismatch_count = 0;
   int                    cycle_count    = 0;
   int                    items_sent     = 0;
   int                    send_gap_pct   = 0;
   int                    rsp_gap_pct    = 0;
   int                    hold_asks      = 0;
   int                    hold_seen      = 0;
   int                    hold_left      = 0;

   partition_fit_allocator i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_load_index       (req_load_index),
      .req_size_value       (req_size_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_granted          (rsp_granted),
      .rsp_chosen_partition (rsp_chosen_partition),
      .rsp_leftover_space   (rsp_leftover_space),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #6 clock = ~clock;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Number of partitions actually scanned: the count register clipped to the table.
   function automatic int unsigned scan_span();
      return (cur_count > PARTITIONS) ? PARTITIONS : int'(cur_count);
   endfunction

   // Apply one allocation request to the predicted table and return its result.
   function automatic result_type serve_request(input logic [SIZE_W-1:0] need);
      int unsigned span;
      int unsigned pos;
      int unsigned pick;
      bit          hit;
      logic [SIZE_W-1:0] gap;
      result_type  res;
      span = scan_span();
      hit  = 1'b0;
      pick = 0;
      gap  = '0;
      case (cur_mode)
         FIT_FIRST: begin
            for (int unsigned k = 0; k < span; k++) begin
               if (!hit && part_free[k] >= need) begin
                  hit  = 1'b1;
                  pick = k;
               end
            end
         end
         FIT_BEST: begin
            // smallest leftover among unmarked partitions; strict < keeps the first on a tie
            for (int unsigned k = 0; k < span; k++) begin
               if (!part_taken[k] && part_free[k] >= need &&
                   (!hit || SIZE_W'(part_free[k] - need) < gap)) begin
                  hit  = 1'b1;
                  pick = k;
                  gap  = part_free[k] - need;
               end
            end
         end
         FIT_WORST: begin
            for (int unsigned k = 0; k < span; k++) begin
               if (part_free[k] >= need && (!hit || part_free[k] > part_free[pick])) begin
                  hit  = 1'b1;
                  pick = k;
               end
            end
         end
         default: begin
            // round robin; a pointer beyond the span restarts at zero
            pos = (rr_ptr < span) ? rr_ptr : 0;
            for (int unsigned k = 0; k < span; k++) begin
               if (!hit && part_free[pos] >= need) begin
                  hit  = 1'b1;
                  pick = pos;
               end
               pos = (pos + 1 >= span) ? 0 : pos + 1;
            end
         end
      endcase
      if (hit) begin
         if (cur_mode == FIT_BEST) begin
            part_taken[pick] = 1'b1;
         end else begin
            part_free[pick] = part_free[pick] - need;
            gap             = part_free[pick];
         end
         if (cur_mode == FIT_NEXT) begin
            rr_ptr = (pick + 1 < span) ? pick + 1 : 0;
         end
      end
      res.granted          = hit;
      res.chosen_partition = hit ? PICK_W'(pick) : '0;
      res.leftover_space   = hit ? gap : '0;
      return res;
   endfunction

   // Watch all three channels at the rising edge; inputs only move at the falling one.
   always @(posedge clock) begin : watch_bus
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIT_MODE) begin
               cur_mode = fit_mode_type'(csr_wdata[1:0]);
            end else begin
               cur_count = csr_wdata;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (alloc_expect_q.size() == 0) begin
               report_mismatch("result with none pending, partition", rsp_chosen_partition, 0);
            end else begin
               want = alloc_expect_q.pop_front();
               if (rsp_granted !== want.granted) begin
                  report_mismatch("granted", rsp_granted, want.granted);
               end
               if (rsp_chosen_partition !== want.chosen_partition) begin
                  report_mismatch("chosen_partition", rsp_chosen_partition,
                                  want.chosen_partition);
               end
               if (rsp_leftover_space !== want.leftover_space) begin
                  report_mismatch("leftover_space", rsp_leftover_space, want.leftover_space);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_LOAD) begin
               // load: set the free size, clear the used mark, no result
               part_free[req_load_index]  = req_size_value;
               part_taken[req_load_index] = 1'b0;
            end else begin
               want = serve_request(req_size_value);
               alloc_expect_q.push_back(row_typed ? row_want : want);
            end
         end
      end
   end

   // Receiver: a requested hold-off wins, otherwise stall at the phase's rate.
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_gap_pct);
      end
   end

   // Offer one transaction; call at a falling edge, returns at the accepting rising edge.
   task automatic offer(input logic [KIND_W-1:0] kind, input logic [LOAD_IDX_W-1:0] index,
                        input logic [SIZE_W-1:0] size, input bit typed,
                        input result_type want);
      // idle the sender at random before raising valid
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_load_index <= index;
      req_size_value <= size;
      row_typed      <= typed;
      row_want       <= want;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Hold until every expected result has been taken.
   task automatic wait_drained();
      while (alloc_expect_q.size() != 0) @(posedge clock);
   endtask

   // Write a register with the block idle: drain, let any trailing load settle, then write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] which,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly small sizes so requests land; some across the full range.
   function automatic logic [SIZE_W-1:0] pick_load_size();
      return ($urandom_range(99) < 70) ? SIZE_W'($urandom_range(2000)) : SIZE_W'($urandom);
   endfunction

   // Request sizes: small, exact fits (zero leftover), zero, the maximum, and full range.
   function automatic logic [SIZE_W-1:0] pick_request_size(input int unsigned span);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40) begin
         return SIZE_W'($urandom_range(300));
      end else if (roll < 65 && span != 0) begin
         return part_free[$urandom_range(span - 1)];
      end else if (roll < 75) begin
         return '0;
      end else if (roll < 80) begin
         return '1;
      end
      return SIZE_W'($urandom);
   endfunction

   // Partition counts: mostly small to keep scans short, with the extremes now and then.
   function automatic logic [CSR_DATA_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         return '0;
      end else if (roll < 15) begin
         return CSR_DATA_W'($urandom_range(2, 1));
      end else if (roll < 75) begin
         return CSR_DATA_W'($urandom_range(8, 3));
      end else if (roll < 88) begin
         return CSR_DATA_W'($urandom_range(31, 9));
      end else if (roll < 95) begin
         return CSR_DATA_W'(PARTITIONS);
      end
      return CSR_DATA_W'($urandom_range(63, PARTITIONS + 1));
   endfunction

   // One random segment: pick a setting, fill the searched partitions, then mixed traffic.
   task automatic run_segment(input int n_items);
      logic [CSR_DATA_W-1:0] cnt;
      int unsigned           span;
      cnt = pick_count();
      write_reg(CSR_FIT_MODE, CSR_DATA_W'($urandom_range(3)));
      write_reg(CSR_PART_COUNT, cnt);
      span = (cnt > PARTITIONS) ? PARTITIONS : int'(cnt);
      for (int unsigned k = 0; k < span; k++) begin
         @(negedge clock);
         offer(KIND_LOAD, LOAD_IDX_W'(k), pick_load_size(), 1'b0, NONE);
      end
      for (int i = 0; i < n_items; i++) begin
         @(negedge clock);
         if ($urandom_range(99) < 35) begin
            offer(KIND_LOAD, LOAD_IDX_W'($urandom), pick_load_size(), 1'b0, NONE);
         end else begin
            offer(KIND_REQUEST, LOAD_IDX_W'($urandom), pick_request_size(span), 1'b0, NONE);
         end
      end
   endtask

   // Cycle counter; end the run if it overruns.
   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int phase_start;
      // hold reset, then release it at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      send_gap_pct = 37;
      rsp_gap_pct  = 83;
      foreach (DIRECTED_ROWS[r]) begin
         case (DIRECTED_ROWS[r].op)
            OP_MODE: begin
               write_reg(CSR_FIT_MODE, CSR_DATA_W'(DIRECTED_ROWS[r].value));
            end
            OP_COUNT: begin
               write_reg(CSR_PART_COUNT, CSR_DATA_W'(DIRECTED_ROWS[r].value));
            end
            default: begin
               @(negedge clock);
               offer((DIRECTED_ROWS[r].op == OP_LOAD) ? KIND_LOAD : KIND_REQUEST,
                     DIRECTED_ROWS[r].index, DIRECTED_ROWS[r].value,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
            end
         endcase
      end

      // random phases: sender-light/receiver-heavy, then swapped, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 37;
               rsp_gap_pct  = 83;
            end
            1: begin
               send_gap_pct = 83;
               rsp_gap_pct  = 37;
            end
            default: begin
               send_gap_pct = 0;
               rsp_gap_pct  = 0;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            run_segment($urandom_range(40, 15));
         end
         if (phase == 0) begin
            // long receiver hold-off while requests keep coming back to back,
            // so the result register fills and the input stalls
            send_gap_pct = 0;
            hold_asks++;
            for (int i = 0; i < 24; i++) begin
               @(negedge clock);
               offer(KIND_REQUEST, LOAD_IDX_W'($urandom), pick_request_size(scan_span()),
                     1'b0, NONE);
            end
            send_gap_pct = 37;
         end
      end

      // drop valid, drain, settle, then judge
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (alloc_expect_q.size() != 0) begin
         report_mismatch("results never delivered", 0, alloc_expect_q.size());
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
